### rtl/core/mtfs_pkg.sv
// shared types and constants for the move-to-front search list
// no dependencies; imported by every module of the block
package mtfs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 8;
    localparam int TOTAL_W       = 9;
    localparam int GROUP         = 8;   // match bits resolved per scan cycle

    typedef enum logic [1:0] {
        FUNC_LOAD         = 2'd0,
        FUNC_SEARCH_MTF   = 2'd1,
        FUNC_SEARCH_PLAIN = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]                 func;
        logic                       start_new;
        logic signed [VALUE_W-1:0]  item_value;
    } in_item_t;

    typedef struct packed {
        logic                       found;
        logic [POS_W-1:0]           position;
        logic                       full_error;
        logic [TOTAL_W-1:0]         entry_total;
    } out_item_t;

    typedef struct packed {
        logic                       wr_en;
        logic                       cmp_en;
        logic                       shift_en;
        logic [POS_W-1:0]           wr_pos;
        logic [POS_W-1:0]           hit_pos;
        logic [TOTAL_W-1:0]         count;
        logic signed [VALUE_W-1:0]  data;
    } cell_ctrl_t;

endpackage

### rtl/core/mtfs_cell.sv
// one list cell: holds an entry, compares it with the key, shifts from its neighbour
// depends on mtfs_pkg
module mtfs_cell (
    input  logic                               aclk,
    input  mtfs_pkg::cell_ctrl_t               ctrl,
    input  logic [mtfs_pkg::POS_W-1:0]         cell_index,
    input  logic signed [mtfs_pkg::VALUE_W-1:0] prev_value,
    output logic signed [mtfs_pkg::VALUE_W-1:0] value,
    output logic                               match
);
    import mtfs_pkg::*;

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      match_reg, match_next;
    logic                      in_use;

    // entries at or beyond the count never match
    assign in_use = {1'b0, cell_index} < ctrl.count;

    always_comb begin
        value_next = value_reg;
        if (ctrl.wr_en && ctrl.wr_pos == cell_index) begin
            value_next = ctrl.data;
        end else if (ctrl.shift_en && cell_index <= ctrl.hit_pos) begin
            value_next = prev_value;
        end
    end

    always_comb begin
        match_next = match_reg;
        if (ctrl.cmp_en) begin
            match_next = in_use && (value_reg == ctrl.data);
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

### rtl/core/mtfs_ctrl.sv
// sequencer: request intake, segmented first-match scan, move-to-front shift, result register
// depends on mtfs_pkg
module mtfs_ctrl #(
    parameter int DEPTH = mtfs_pkg::DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mtfs_pkg::in_item_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mtfs_pkg::out_item_t   m_item,
    input  logic [DEPTH-1:0]      match_vec,
    output mtfs_pkg::cell_ctrl_t  cell_ctrl
);
    import mtfs_pkg::*;

    localparam int NSEG  = (DEPTH + GROUP - 1) / GROUP;
    localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;
    localparam int GRP_W = $clog2(GROUP);
    localparam int PAD_W = NSEG * GROUP;

    state_t                    state_reg, state_next;
    logic [SEG_W-1:0]          seg_reg, seg_next;
    logic [TOTAL_W-1:0]        count_reg, count_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      mtf_reg, mtf_next;
    out_item_t                 res_reg, res_next;
    logic                      m_valid_reg, m_valid_next;
    out_item_t                 m_item_reg, m_item_next;

    logic                      accept;
    logic                      is_load, is_search;
    logic                      full_err;
    logic [TOTAL_W-1:0]        wr_idx;
    logic [PAD_W-1:0]          match_pad;
    logic [GROUP-1:0]          window;
    logic                      win_hit;
    logic [GRP_W-1:0]          win_first;
    logic [POS_W-1:0]          hit_pos;
    logic                      last_seg;
    logic                      out_free;

    assign accept    = s_valid && s_ready;
    assign is_load   = s_item.func == FUNC_LOAD;
    assign is_search = s_item.func == FUNC_SEARCH_MTF || s_item.func == FUNC_SEARCH_PLAIN;
    assign full_err  = !s_item.start_new && count_reg >= TOTAL_W'(DEPTH);
    assign wr_idx    = s_item.start_new ? '0 : count_reg;

    assign match_pad = PAD_W'(match_vec);
    assign window    = match_pad[seg_reg * GROUP +: GROUP];
    assign last_seg  = seg_reg == SEG_W'(NSEG - 1);
    assign hit_pos   = POS_W'({seg_reg, win_first});
    assign out_free  = !m_valid_reg || m_ready;

    // lowest set bit of the current group
    always_comb begin
        win_hit   = 1'b0;
        win_first = '0;
        for (int b = GROUP - 1; b >= 0; b--) begin
            if (window[b]) begin
                win_hit   = 1'b1;
                win_first = GRP_W'(b);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = is_search ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (win_hit) begin
                    state_next = (mtf_reg && hit_pos != '0) ? ST_SHIFT : ST_FINISH;
                end else if (last_seg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs to the channel and the cell chain
    always_comb begin
        s_ready            = state_reg == ST_IDLE;
        cell_ctrl.wr_en    = accept && is_load && !full_err;
        cell_ctrl.cmp_en   = accept && is_search;
        cell_ctrl.shift_en = state_reg == ST_SHIFT;
        cell_ctrl.wr_pos   = POS_W'(wr_idx);
        cell_ctrl.hit_pos  = res_reg.position;
        cell_ctrl.count    = count_reg;
        cell_ctrl.data     = (state_reg == ST_IDLE) ? s_item.item_value : key_reg;
    end

    // datapath
    always_comb begin
        seg_next     = seg_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        mtf_next     = mtf_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            key_next             = s_item.item_value;
            mtf_next             = s_item.func == FUNC_SEARCH_MTF;
            seg_next             = '0;
            res_next.found       = 1'b0;
            res_next.position    = '0;
            res_next.full_error  = 1'b0;
            res_next.entry_total = count_reg;
            if (is_load) begin
                if (full_err) begin
                    res_next.full_error = 1'b1;
                end else begin
                    res_next.position    = POS_W'(wr_idx);
                    res_next.entry_total = wr_idx + TOTAL_W'(1);
                    count_next           = wr_idx + TOTAL_W'(1);
                end
            end
        end

        if (state_reg == ST_SCAN) begin
            if (win_hit) begin
                res_next.found    = 1'b1;
                res_next.position = hit_pos;
            end else if (!last_seg) begin
                seg_next = seg_reg + SEG_W'(1);
            end
        end

        if (state_reg == ST_FINISH && out_free) begin
            m_valid_next = 1'b1;
            m_item_next  = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        seg_reg    <= seg_next;
        key_reg    <= key_next;
        mtf_reg    <= mtf_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // the shift step only ever follows a scan hit
    a_shift_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> $past(state_reg) == ST_SCAN)
        else $error("shift entered without a preceding scan");

    // the count never exceeds the list depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= TOTAL_W'(DEPTH))
        else $error("entry count beyond depth");

    // a new result appears only out of the finish step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish");

    // the list length holds still while a search is being scanned
    a_count_stable_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("count changed during scan");

endmodule

### rtl/core/move_to_front_search_list.sv
// top level of the move-to-front search list: row of list cells plus the sequencer
// depends on mtfs_pkg, mtfs_cell and mtfs_ctrl
//
//   channel   direction   payload                 handshake
//   s_        in          mtfs_pkg::in_item_t     s_valid / s_ready
//   m_        out         mtfs_pkg::out_item_t    m_valid / m_ready
//
// a load or an unused code goes from the request step straight to the finish step
// a search scans 1 .. ceil(DEPTH/8) groups up to the first match, then a move-to-front
// hit off the head adds a shift step; the first-match scan resolves 8 cell match flags per cycle
// reset clears the count and handshake state only; entries hold no reset value
// a request is taken while an earlier result still waits in the output register;
// the finish step stalls until that register is free
module move_to_front_search_list #(
    parameter int DEPTH = mtfs_pkg::DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mtfs_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mtfs_pkg::out_item_t  m_item
);
    import mtfs_pkg::*;

    cell_ctrl_t                cell_ctrl;
    logic [DEPTH-1:0]          match_vec;
    logic signed [VALUE_W-1:0] cell_value [DEPTH];

    // sequencer: owns the count, the scan and the result register
    mtfs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .match_vec (match_vec),
        .cell_ctrl (cell_ctrl)
    );

    // row of cells; each shifts from the one ahead, the head takes the key
    // (on a hit the key equals the entry being moved forward)
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_value;

        if (i == 0) begin : g_head
            assign prev_value = cell_ctrl.data;
        end else begin : g_body
            assign prev_value = cell_value[i-1];
        end

        mtfs_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .cell_index (POS_W'(i)),
            .prev_value (prev_value),
            .value      (cell_value[i]),
            .match      (match_vec[i])
        );
    end

endmodule
